// ===== src/bplfm_pkg.sv =====
// Shared constants and command codes for the buffer pool frame manager.
// No dependencies; used by bplfm_cell and the top level.
package bplfm_pkg;

  // Default sizing, handed down through top-level parameters
  localparam int FRAMES_DEF         = 16;
  localparam int TABLE_ID_BITS_DEF  = 8;
  localparam int BLOCK_NUM_BITS_DEF = 24;

  // Width of the last-access stamp and the access clock
  localparam int STAMP_W = 32;

  // Request commands
  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_ALLOC  = 2'd1,
    CMD_DROP   = 2'd2,
    CMD_MARK   = 2'd3
  } cmd_t;

endpackage

// ===== src/buffer_pool_lru_frame_manager_top.sv =====
// Buffer pool frame manager with least-recently-used replacement: a chain of
// frame cells and the request sequencer. Depends on bplfm_pkg and bplfm_cell.
//
//   channel  handshake          beat contents
//   in_      start / busy       command, table id, block number, frame index
//   out_     out_valid strobe   frame, hit, writeback, fill/write flags, error
//
// Each request is handled in two phases: the search result walks the cell
// chain one frame per cycle, then the update state writes the chosen frame
// and registers the result. busy is high from the accepting edge until the
// result beat is shown; the next request is taken at the edge that ends that
// beat, so a new request is taken only once the last result is out.
// Reset (synchronous, rst_n low) clears every frame and the access clock.
// The receiver cannot stall: each result is on the out_ ports for one cycle.
module buffer_pool_lru_frame_manager_top #(
  parameter int FRAMES         = bplfm_pkg::FRAMES_DEF,
  parameter int TABLE_ID_BITS  = bplfm_pkg::TABLE_ID_BITS_DEF,
  parameter int BLOCK_NUM_BITS = bplfm_pkg::BLOCK_NUM_BITS_DEF,
  localparam int FW            = (FRAMES > 1) ? $clog2(FRAMES) : 1,
  localparam int SBW           = BLOCK_NUM_BITS - 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      in_command,
  input  logic [TABLE_ID_BITS-1:0]        in_table_id,
  input  logic signed [BLOCK_NUM_BITS-1:0] in_block_number,
  input  logic [FW-1:0]                   in_frame_index,
  output logic                            out_valid,
  output logic [FW-1:0]                   out_frame,
  output logic                            out_hit,
  output logic                            out_writeback_needed,
  output logic [TABLE_ID_BITS-1:0]        out_writeback_table,
  output logic [SBW-1:0]                  out_writeback_block,
  output logic                            out_fill_read,
  output logic                            out_new_block_write,
  output logic                            out_error
);

  localparam int SW = bplfm_pkg::STAMP_W;
  localparam int CW = 3 * FW + 3 + SW + 1 + TABLE_ID_BITS + SBW;
  localparam int UW = 4 + FW + SW + 2 + FW;

  typedef struct packed {
    logic                     hit;
    logic [FW-1:0]            hit_idx;
    logic                     inv_found;
    logic [FW-1:0]            inv_idx;
    logic                     best_ok;
    logic [FW-1:0]            best_idx;
    logic [SW-1:0]            best_stamp;
    logic                     best_dirty;
    logic [TABLE_ID_BITS-1:0] best_table;
    logic [SBW-1:0]           best_block;
  } carry_t;

  typedef struct packed {
    logic          wr_en;
    logic          set_tag;
    logic          clear_dirty;
    logic          drop_en;
    logic [FW-1:0] wr_idx;
    logic [SW-1:0] stamp;
    logic          mark_en;
    logic          spare;
    logic [FW-1:0] mark_idx;
  } upd_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_UPDATE = 3'b100
  } state_t;

  state_t                    state_r, state_nxt;
  logic [FW-1:0]             cnt_r, cnt_nxt;
  bplfm_pkg::cmd_t           cmd_r;
  logic [TABLE_ID_BITS-1:0]  table_r;
  logic [BLOCK_NUM_BITS-1:0] block_r;
  logic [FW-1:0]             fidx_r;
  logic [SW-1:0]             clock_r, clock_nxt;

  logic                      valid_r, valid_nxt;
  logic [FW-1:0]             frame_r, frame_nxt;
  logic                      hit_r, hit_nxt;
  logic                      wb_r, wb_nxt;
  logic [TABLE_ID_BITS-1:0]  wb_table_r, wb_table_nxt;
  logic [SBW-1:0]            wb_block_r, wb_block_nxt;
  logic                      fill_r, fill_nxt;
  logic                      nbw_r, nbw_nxt;
  logic                      err_r, err_nxt;

  logic [CW-1:0]             carry_w [FRAMES];
  carry_t                    res;
  upd_t                      upd;
  logic                      accept;
  logic                      negative;
  logic                      idx_ok;
  logic [SBW-1:0]            req_sblock;

  assign accept     = start && (state_r == ST_IDLE);
  assign busy       = (state_r != ST_IDLE);
  assign res        = carry_t'(carry_w[FRAMES-1]);
  assign negative   = block_r[BLOCK_NUM_BITS-1];
  assign req_sblock = block_r[SBW-1:0];
  assign idx_ok     = ({1'b0, fidx_r} < (FW + 1)'(FRAMES));

  // Frame cells; each hands its search stage to the next
  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    logic [CW-1:0] cin;
    if (i == 0) begin : g_head
      assign cin = '0;
    end else begin : g_link
      assign cin = carry_w[i-1];
    end
    bplfm_cell #(
      .FRAMES         (FRAMES),
      .TABLE_ID_BITS  (TABLE_ID_BITS),
      .BLOCK_NUM_BITS (BLOCK_NUM_BITS),
      .CELL_IDX       (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .req_table (table_r),
      .req_block (req_sblock),
      .carry_i   (cin),
      .carry_o   (carry_w[i]),
      .upd_i     (UW'(upd))
    );
  end

  // Sequence: scan the chain, then the update state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_SCAN;
          cnt_nxt   = '0;
        end
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == FW'(FRAMES - 1)) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Decide the frame write and the result beat from the chain's end
  always_comb begin
    upd          = '0;
    clock_nxt    = clock_r;
    valid_nxt    = 1'b0;
    frame_nxt    = '0;
    hit_nxt      = 1'b0;
    wb_nxt       = 1'b0;
    wb_table_nxt = '0;
    wb_block_nxt = '0;
    fill_nxt     = 1'b0;
    nbw_nxt      = 1'b0;
    err_nxt      = 1'b0;
    upd.mark_idx = fidx_r;
    if (state_r == ST_UPDATE) begin
      valid_nxt = 1'b1;
      case (cmd_r)
        bplfm_pkg::CMD_LOOKUP, bplfm_pkg::CMD_ALLOC: begin
          if (negative) begin
            err_nxt = 1'b1;
          end else begin
            clock_nxt = clock_r + 1'b1;
            upd.wr_en = 1'b1;
            upd.stamp = clock_nxt;
            if (res.hit) begin
              upd.wr_idx      = res.hit_idx;
              upd.clear_dirty = (cmd_r == bplfm_pkg::CMD_ALLOC);
              hit_nxt         = 1'b1;
              nbw_nxt         = (cmd_r == bplfm_pkg::CMD_ALLOC);
            end else begin
              // miss: take a free frame if any, else evict the oldest stamp
              upd.wr_idx      = res.inv_found ? res.inv_idx : res.best_idx;
              upd.set_tag     = 1'b1;
              upd.clear_dirty = 1'b1;
              if (!res.inv_found && res.best_dirty) begin
                wb_nxt       = 1'b1;
                wb_table_nxt = res.best_table;
                wb_block_nxt = res.best_block;
              end
              fill_nxt = (cmd_r == bplfm_pkg::CMD_LOOKUP);
              nbw_nxt  = (cmd_r == bplfm_pkg::CMD_ALLOC);
            end
            frame_nxt = upd.wr_idx;
          end
        end
        bplfm_pkg::CMD_DROP: begin
          upd.drop_en = 1'b1;
        end
        bplfm_pkg::CMD_MARK: begin
          frame_nxt   = fidx_r;
          upd.mark_en = idx_ok;
        end
        default: begin
          valid_nxt = 1'b1;
        end
      endcase
    end
  end

  // Hold request and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      clock_r <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      clock_r <= clock_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= bplfm_pkg::cmd_t'(in_command);
      table_r <= in_table_id;
      block_r <= in_block_number;
      fidx_r  <= in_frame_index;
    end
    frame_r    <= frame_nxt;
    hit_r      <= hit_nxt;
    wb_r       <= wb_nxt;
    wb_table_r <= wb_table_nxt;
    wb_block_r <= wb_block_nxt;
    fill_r     <= fill_nxt;
    nbw_r      <= nbw_nxt;
    err_r      <= err_nxt;
  end

  assign out_valid            = valid_r;
  assign out_frame            = frame_r;
  assign out_hit              = hit_r;
  assign out_writeback_needed = wb_r;
  assign out_writeback_table  = wb_table_r;
  assign out_writeback_block  = wb_block_r;
  assign out_fill_read        = fill_r;
  assign out_new_block_write  = nbw_r;
  assign out_error            = err_r;

endmodule

// ===== src/bplfm_cell.sv =====
// One frame of the buffer pool: tag, valid, dirty and stamp, plus one stage
// of the search chain. Depends on bplfm_pkg.
module bplfm_cell #(
  parameter int FRAMES         = bplfm_pkg::FRAMES_DEF,
  parameter int TABLE_ID_BITS  = bplfm_pkg::TABLE_ID_BITS_DEF,
  parameter int BLOCK_NUM_BITS = bplfm_pkg::BLOCK_NUM_BITS_DEF,
  parameter int CELL_IDX       = 0,
  localparam int FW            = (FRAMES > 1) ? $clog2(FRAMES) : 1,
  localparam int SBW           = BLOCK_NUM_BITS - 1,
  localparam int CW            = 3 * FW + 3 + bplfm_pkg::STAMP_W + 1 + TABLE_ID_BITS + SBW,
  localparam int UW            = 4 + FW + bplfm_pkg::STAMP_W + 2 + FW
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [TABLE_ID_BITS-1:0] req_table,
  input  logic [SBW-1:0]           req_block,
  input  logic [CW-1:0]            carry_i,
  output logic [CW-1:0]            carry_o,
  input  logic [UW-1:0]            upd_i
);

  // Running search result handed from cell to cell
  typedef struct packed {
    logic                          hit;
    logic [FW-1:0]                 hit_idx;
    logic                          inv_found;
    logic [FW-1:0]                 inv_idx;
    logic                          best_ok;
    logic [FW-1:0]                 best_idx;
    logic [bplfm_pkg::STAMP_W-1:0] best_stamp;
    logic                          best_dirty;
    logic [TABLE_ID_BITS-1:0]      best_table;
    logic [SBW-1:0]                best_block;
  } carry_t;

  // Frame write broadcast by the controller in its update cycle
  typedef struct packed {
    logic                          wr_en;
    logic                          set_tag;
    logic                          clear_dirty;
    logic                          drop_en;
    logic [FW-1:0]                 wr_idx;
    logic [bplfm_pkg::STAMP_W-1:0] stamp;
    logic                          mark_en;
    logic                          spare;
    logic [FW-1:0]                 mark_idx;
  } upd_t;

  localparam logic [FW-1:0] MY_IDX = FW'(CELL_IDX);

  logic                          valid_r, valid_nxt;
  logic                          dirty_r, dirty_nxt;
  logic [TABLE_ID_BITS-1:0]      table_r, table_nxt;
  logic [SBW-1:0]                block_r, block_nxt;
  logic [bplfm_pkg::STAMP_W-1:0] stamp_r, stamp_nxt;
  carry_t                        cin;
  carry_t                        carry_r, carry_nxt;
  upd_t                          upd;
  logic                          tag_hit;

  assign cin     = carry_t'(carry_i);
  assign upd     = upd_t'(upd_i);
  assign carry_o = CW'(carry_r);
  assign tag_hit = valid_r && (table_r == req_table) && (block_r == req_block);

  // Fold this frame into the running search result
  always_comb begin
    carry_nxt = cin;
    if (!cin.hit && tag_hit) begin
      carry_nxt.hit     = 1'b1;
      carry_nxt.hit_idx = MY_IDX;
    end
    if (!cin.inv_found && !valid_r) begin
      carry_nxt.inv_found = 1'b1;
      carry_nxt.inv_idx   = MY_IDX;
    end
    // strict compare keeps the lowest index on equal stamps
    if (!cin.best_ok || (stamp_r < cin.best_stamp)) begin
      carry_nxt.best_ok    = 1'b1;
      carry_nxt.best_idx   = MY_IDX;
      carry_nxt.best_stamp = stamp_r;
      carry_nxt.best_dirty = dirty_r;
      carry_nxt.best_table = table_r;
      carry_nxt.best_block = block_r;
    end
  end

  // Apply the broadcast update to this frame
  always_comb begin
    valid_nxt = valid_r;
    dirty_nxt = dirty_r;
    table_nxt = table_r;
    block_nxt = block_r;
    stamp_nxt = stamp_r;
    if (upd.wr_en && (upd.wr_idx == MY_IDX)) begin
      if (upd.set_tag) begin
        valid_nxt = 1'b1;
        table_nxt = req_table;
        block_nxt = req_block;
      end
      if (upd.clear_dirty) begin
        dirty_nxt = 1'b0;
      end
      stamp_nxt = upd.stamp;
    end
    if (upd.drop_en && valid_r && (table_r == req_table)) begin
      valid_nxt = 1'b0;
      dirty_nxt = 1'b0;
      table_nxt = '0;
      block_nxt = '0;
      stamp_nxt = '0;
    end
    if (upd.mark_en && (upd.mark_idx == MY_IDX) && valid_r) begin
      dirty_nxt = 1'b1;
    end
  end

  // Hold frame state; advance the search stage every cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      dirty_r <= 1'b0;
      table_r <= '0;
      block_r <= '0;
      stamp_r <= '0;
      carry_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      dirty_r <= dirty_nxt;
      table_r <= table_nxt;
      block_r <= block_nxt;
      stamp_r <= stamp_nxt;
      carry_r <= carry_nxt;
    end
  end

endmodule
